// ===== rtl/qpn_pkg.sv =====
package qpn_pkg;

    // component format: signed, CW bits, FRAC fraction bits
    localparam int CW   = 16;
    localparam int FRAC = CW - 2;
    localparam int TOLW = 15;

    // derived datapath widths
    localparam int PW   = 2 * CW;          // one partial product
    localparam int SW   = PW + 2;          // sum of four products
    localparam int RW   = SW - FRAC;       // rounded product component
    localparam int AW   = RW - 1;          // magnitude of a component
    localparam int SQW  = 2 * AW;          // one square
    localparam int SUMW = SQW + 2;         // sum of four squares
    localparam int MW   = SUMW / 2;        // square root
    localparam int NW   = AW + FRAC + 1;   // scaled dividend plus rounding term
    localparam int DW   = MW + CW;         // divider remainder
    localparam int QBW  = CW;              // quotient bits kept before saturation

    // pipeline stage map
    localparam int N_SQ    = MW;
    localparam int S_IN    = 0;
    localparam int S_PROD  = S_IN + 1;
    localparam int S_R     = S_PROD + 1;
    localparam int S_SQ    = S_R + 1;
    localparam int S_SUM   = S_SQ + 1;
    localparam int S_ROOT0 = S_SUM + 1;
    localparam int S_DEC   = S_ROOT0 + N_SQ;
    localparam int S_OVF   = S_DEC + 1;
    localparam int S_DIV0  = S_OVF + 1;
    localparam int S_OUT   = S_DIV0 + QBW;
    localparam int N_ST    = S_OUT + 1;

    localparam int COMP_MAX_I = 2 ** (CW - 1) - 1;
    localparam int COMP_MIN_I = -(2 ** (CW - 1));
    localparam int ONE_Q_I    = 2 ** FRAC;

    localparam logic [TOLW-1:0] TOL_RESET = TOLW'(1);

    typedef logic signed [CW-1:0] t_comp;
    typedef logic signed [RW-1:0] t_rval;
    typedef logic [AW-1:0]        t_mag;

    typedef enum logic [1:0] {
        MODE_UNIT,
        MODE_RENORM,
        MODE_DEGEN
    } t_mode;

    typedef struct packed {
        t_comp left_x;
        t_comp left_y;
        t_comp left_z;
        t_comp left_w;
        t_comp right_x;
        t_comp right_y;
        t_comp right_z;
        t_comp right_w;
    } t_qpn_in;

    typedef struct packed {
        t_comp prod_x;
        t_comp prod_y;
        t_comp prod_z;
        t_comp prod_w;
        logic  degenerate;
        logic  renormalized;
    } t_qpn_out;

    function automatic t_mag abs_r(t_rval v);
        logic [RW-1:0] a;
        a = v[RW-1] ? RW'(-v) : RW'(v);
        return a[AW-1:0];
    endfunction

    function automatic t_comp sat_r(t_rval v);
        t_comp res;
        if (v > t_rval'(COMP_MAX_I)) begin
            res = t_comp'(COMP_MAX_I);
        end else if (v < t_rval'(COMP_MIN_I)) begin
            res = t_comp'(COMP_MIN_I);
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/qpn_if.sv =====
interface qpn_in_if
    import qpn_pkg::*;
();
    logic    valid;
    logic    ready;
    t_qpn_in payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface qpn_out_if
    import qpn_pkg::*;
();
    logic     valid;
    logic     ready;
    t_qpn_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/quaternion_product_normalize.sv =====
// Hamilton product of two Q2.14 quaternions with renormalization.
// Input channel i_in carries one pair (left, right) per beat; output channel
// o_out carries the product, saturated or divided by its magnitude (or the
// unit quaternion when degenerate), plus the degenerate and renormalized
// flags. i_cfg_we/i_cfg_wdata write the 15-bit magnitude tolerance; write it
// only while no beats are in flight.
// Throughput: one beat per cycle while o_out is not stalled. A beat reaches
// o_out through a chain of 44 registers, the first loaded at the accepting
// edge: input register, products, sum and round, squares, sum of squares,
// 20 square root stages (one root bit each), mode decision, overflow check,
// 16 divider stages (one quotient bit each for all four lanes), output register.
// Reset clears every stage valid bit and sets the tolerance to 1.
// When o_out is stalled with a beat waiting, the whole pipeline holds and
// i_in.ready drops in the same cycle; nothing is lost or repeated.
module quaternion_product_normalize
    import qpn_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    qpn_in_if.sink          i_in,
    qpn_out_if.source       o_out,
    input  logic            i_cfg_we,
    input  logic [TOLW-1:0] i_cfg_wdata
);

    logic            en;
    logic [N_ST-1:0] r_v;
    logic [TOLW-1:0] r_tol;

    t_qpn_in                r_in;
    logic signed [PW-1:0]   r_prod [4][4];
    t_rval                  r_rq [S_R:S_OUT-1][4];
    logic [SQW-1:0]         r_sq [4];
    logic [SUMW-1:0]        r_sum;
    logic [SUMW-1:0]        r_srem [N_SQ];
    logic [MW-1:0]          r_sroot [N_SQ];
    t_mode                  r_mode;
    logic [MW-1:0]          r_mag;
    logic [NW-1:0]          r_num [4];
    logic [DW-1:0]          r_drem [QBW+1][4];
    logic [QBW-1:0]         r_dq [QBW+1][4];
    logic [3:0]             r_ovf [QBW+1];
    logic [MW-1:0]          r_dmag [QBW+1];
    t_mode                  r_dmode [QBW+1];
    t_qpn_out               r_out;

    t_rval                  n_r [4];
    t_mode                  n_mode;
    logic [MW-1:0]          n_absd;
    logic [MW-1:0]          n_mag;
    t_qpn_out               n_out;

    // advance all stages unless a finished beat is waiting
    assign en          = !r_v[N_ST-1] || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_v[N_ST-1];
    assign o_out.payload = r_out;

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // shift valid bits along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[N_ST-2:0], i_in.valid};
        end
    end

    // capture inputs and form the sixteen partial products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_in.payload;
            r_prod[0][0] <= PW'(r_in.left_w) * PW'(r_in.right_x);
            r_prod[0][1] <= PW'(r_in.left_x) * PW'(r_in.right_w);
            r_prod[0][2] <= PW'(r_in.left_y) * PW'(r_in.right_z);
            r_prod[0][3] <= PW'(r_in.left_z) * PW'(r_in.right_y);
            r_prod[1][0] <= PW'(r_in.left_w) * PW'(r_in.right_y);
            r_prod[1][1] <= PW'(r_in.left_y) * PW'(r_in.right_w);
            r_prod[1][2] <= PW'(r_in.left_z) * PW'(r_in.right_x);
            r_prod[1][3] <= PW'(r_in.left_x) * PW'(r_in.right_z);
            r_prod[2][0] <= PW'(r_in.left_w) * PW'(r_in.right_z);
            r_prod[2][1] <= PW'(r_in.left_z) * PW'(r_in.right_w);
            r_prod[2][2] <= PW'(r_in.left_x) * PW'(r_in.right_y);
            r_prod[2][3] <= PW'(r_in.left_y) * PW'(r_in.right_x);
            r_prod[3][0] <= PW'(r_in.left_w) * PW'(r_in.right_w);
            r_prod[3][1] <= PW'(r_in.left_x) * PW'(r_in.right_x);
            r_prod[3][2] <= PW'(r_in.left_y) * PW'(r_in.right_y);
            r_prod[3][3] <= PW'(r_in.left_z) * PW'(r_in.right_z);
        end
    end

    // sum the products and round to nearest, ties up
    always_comb begin
        logic signed [SW-1:0] s [4];
        for (int c = 0; c < 3; c++) begin
            s[c] = SW'(r_prod[c][0]) + SW'(r_prod[c][1]) + SW'(r_prod[c][2])
                 - SW'(r_prod[c][3]) + (SW'(1) <<< (FRAC - 1));
        end
        s[3] = SW'(r_prod[3][0]) - SW'(r_prod[3][1]) - SW'(r_prod[3][2])
             - SW'(r_prod[3][3]) + (SW'(1) <<< (FRAC - 1));
        for (int c = 0; c < 4; c++) begin
            n_r[c] = s[c][SW-1:FRAC];
        end
    end

    // carry the rounded components down the pipeline
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rq[S_R] <= n_r;
            for (int s = S_R + 1; s < S_OUT; s++) begin
                r_rq[s] <= r_rq[s-1];
            end
        end
    end

    // squares and their sum
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                r_sq[c] <= SQW'(abs_r(r_rq[S_R][c])) * SQW'(abs_r(r_rq[S_R][c]));
            end
            r_sum <= SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]) + SUMW'(r_sq[3]);
        end
    end

    // floor square root, one root bit per stage
    for (genvar g = 0; g < N_SQ; g++) begin : g_root
        localparam int J = MW - 1 - g;
        logic [SUMW-1:0] rem_i;
        logic [MW-1:0]   root_i;
        logic [SUMW-1:0] cand;

        if (g == 0) begin : g_first
            assign rem_i  = r_sum;
            assign root_i = '0;
        end else begin : g_next
            assign rem_i  = r_srem[g-1];
            assign root_i = r_sroot[g-1];
        end

        assign cand = (SUMW'(root_i) << (J + 1)) | (SUMW'(1) << (2 * J));

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (rem_i >= cand) begin
                    r_srem[g]  <= rem_i - cand;
                    r_sroot[g] <= root_i | (MW'(1) << J);
                end else begin
                    r_srem[g]  <= rem_i;
                    r_sroot[g] <= root_i;
                end
            end
        end
    end

    // pick unit, renormalize or degenerate handling
    always_comb begin
        n_mag = r_sroot[N_SQ-1];
        if (n_mag >= MW'(ONE_Q_I)) begin
            n_absd = n_mag - MW'(ONE_Q_I);
        end else begin
            n_absd = MW'(ONE_Q_I) - n_mag;
        end
        if (n_absd < MW'(r_tol)) begin
            n_mode = MODE_UNIT;
        end else if (n_mag > MW'(r_tol) && n_mag != '0) begin
            n_mode = MODE_RENORM;
        end else begin
            n_mode = MODE_DEGEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mode <= n_mode;
            r_mag  <= n_mag;
            for (int c = 0; c < 4; c++) begin
                r_num[c] <= NW'({abs_r(r_rq[S_DEC-1][c]), {FRAC{1'b0}}})
                          + NW'(n_mag >> 1);
            end
        end
    end

    // flag quotients too large for the kept bits, seed the divider
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dmag[0]  <= r_mag;
            r_dmode[0] <= r_mode;
            for (int c = 0; c < 4; c++) begin
                r_ovf[0][c]  <= DW'(r_num[c]) >= (DW'(r_mag) << QBW);
                r_drem[0][c] <= DW'(r_num[c]);
                r_dq[0][c]   <= '0;
            end
        end
    end

    // restoring division, one quotient bit per stage on all lanes
    for (genvar d = 1; d <= QBW; d++) begin : g_div
        localparam int J = QBW - d;
        logic [DW-1:0] dv;

        assign dv = DW'(r_dmag[d-1]) << J;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dmag[d]  <= r_dmag[d-1];
                r_dmode[d] <= r_dmode[d-1];
                r_ovf[d]   <= r_ovf[d-1];
                for (int c = 0; c < 4; c++) begin
                    if (r_drem[d-1][c] >= dv) begin
                        r_drem[d][c] <= r_drem[d-1][c] - dv;
                        r_dq[d][c]   <= r_dq[d-1][c] | (QBW'(1) << J);
                    end else begin
                        r_drem[d][c] <= r_drem[d-1][c];
                        r_dq[d][c]   <= r_dq[d-1][c];
                    end
                end
            end
        end
    end

    // select and saturate the result
    always_comb begin
        t_comp res [4];
        logic  neg;
        logic [QBW-1:0] q;
        for (int c = 0; c < 4; c++) begin
            neg = r_rq[S_OUT-1][c][RW-1];
            q   = r_dq[QBW][c];
            res[c] = '0;
            case (r_dmode[QBW])
                MODE_UNIT: begin
                    res[c] = sat_r(r_rq[S_OUT-1][c]);
                end
                MODE_RENORM: begin
                    if (r_ovf[QBW][c] || q[QBW-1]) begin
                        res[c] = neg ? t_comp'(COMP_MIN_I) : t_comp'(COMP_MAX_I);
                    end else begin
                        res[c] = neg ? t_comp'(-q) : t_comp'(q);
                    end
                end
                default: begin
                    res[c] = (c == 3) ? t_comp'(ONE_Q_I) : '0;
                end
            endcase
        end
        n_out.prod_x       = res[0];
        n_out.prod_y       = res[1];
        n_out.prod_z       = res[2];
        n_out.prod_w       = res[3];
        n_out.degenerate   = (r_dmode[QBW] == MODE_DEGEN);
        n_out.renormalized = (r_dmode[QBW] == MODE_RENORM);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== tb/qpn_tb_if.sv =====
`timescale 1ns / 1ps

// Local copies are not needed: the block's own interfaces are used directly.
// This file holds a small probe interface that the testbench uses to watch
// both channels from one place.
interface qpn_watch_if (
    input logic i_clk
);
    logic in_beat;
    logic out_beat;

    modport source (output in_beat, output out_beat);
    modport sink   (input i_clk, input in_beat, input out_beat);
endinterface

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import qpn_pkg::*;

    localparam int LATENCY    = 44;
    localparam int IDLE_LIMIT = 4000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_we = 1'b0;
    logic [TOLW-1:0] i_cfg_wdata = '0;

    qpn_in_if  in_ch ();
    qpn_out_if out_ch ();
    qpn_watch_if watch (.i_clk(i_clk));

    quaternion_product_normalize dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
    end

    assign watch.in_beat  = in_ch.valid && in_ch.ready;
    assign watch.out_beat = out_ch.valid && out_ch.ready;

    t_qpn_out    expected_products[$];
    logic [14:0] tolerance = TOL_RESET;
    int          error_count = 0;
    int          beats_sent = 0;
    int          beats_checked = 0;
    int          renorm_seen = 0;
    int          degen_seen = 0;
    int          unit_seen = 0;
    int          idle_cycles = 0;
    bit          send_idles = 1'b1;
    bit          sink_idles = 1'b1;
    bit          hold_sink = 1'b0;

    // floor integer square root
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint clamp_comp(longint v);
        if (v > COMP_MAX_I) return COMP_MAX_I;
        if (v < COMP_MIN_I) return COMP_MIN_I;
        return v;
    endfunction

    // Hamilton product, magnitude and mode decision
    function automatic t_qpn_out hamilton_normalize(t_qpn_in q, logic [14:0] tol);
        longint lx, ly, lz, lw, rx, ry, rz, rw;
        longint exact[4];
        longint comp[4];
        longint unsigned sumsq, mag, num;
        longint diff, quo;
        t_qpn_out res;
        lx = q.left_x;  ly = q.left_y;  lz = q.left_z;  lw = q.left_w;
        rx = q.right_x; ry = q.right_y; rz = q.right_z; rw = q.right_w;
        exact[0] = lw * rx + lx * rw + ly * rz - lz * ry;
        exact[1] = lw * ry + ly * rw + lz * rx - lx * rz;
        exact[2] = lw * rz + lz * rw + lx * ry - ly * rx;
        exact[3] = lw * rw - lx * rx - ly * ry - lz * rz;
        sumsq = 0;
        // round to nearest, ties up
        for (int i = 0; i < 4; i++) begin
            comp[i] = (exact[i] + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
            sumsq += longint'(comp[i] * comp[i]);
        end
        mag  = floor_sqrt(sumsq);
        diff = longint'(mag) - ONE_Q_I;
        if (diff < 0) diff = -diff;
        res = '0;
        if (diff < longint'(tol)) begin
            res.prod_x = t_comp'(clamp_comp(comp[0]));
            res.prod_y = t_comp'(clamp_comp(comp[1]));
            res.prod_z = t_comp'(clamp_comp(comp[2]));
            res.prod_w = t_comp'(clamp_comp(comp[3]));
        end else if (longint'(mag) > longint'(tol) && mag != 0) begin
            res.renormalized = 1'b1;
            for (int i = 0; i < 4; i++) begin
                num = (comp[i] < 0 ? -comp[i] : comp[i]) << FRAC;
                quo = longint'((num + mag / 2) / mag);
                comp[i] = clamp_comp(comp[i] < 0 ? -quo : quo);
            end
            res.prod_x = t_comp'(comp[0]);
            res.prod_y = t_comp'(comp[1]);
            res.prod_z = t_comp'(comp[2]);
            res.prod_w = t_comp'(comp[3]);
        end else begin
            res.degenerate = 1'b1;
            res.prod_w     = t_comp'(ONE_Q_I);
        end
        return res;
    endfunction

    // send one beat, holding valid across back-to-back beats
    task automatic send_pair(t_qpn_in q);
        while (send_idles && $urandom_range(99) < 25) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= q;
        expected_products.push_back(hamilton_normalize(q, tolerance));
        do @(posedge i_clk); while (!in_ch.ready);
        beats_sent++;
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_products.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [14:0] value);
        go_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tolerance = value;
    endtask

    function automatic t_qpn_in make_pair(t_comp a, t_comp b, t_comp c, t_comp d,
                                          t_comp e, t_comp f, t_comp g, t_comp h);
        t_qpn_in q;
        q = '{a, b, c, d, e, f, g, h};
        return q;
    endfunction

    function automatic t_comp rand_comp();
        t_comp v;
        case ($urandom_range(5))
            0: v = t_comp'($urandom);
            1: v = $urandom_range(1) ? t_comp'(COMP_MAX_I) : t_comp'(COMP_MIN_I);
            2: v = t_comp'($urandom_range(64) - 32);
            default: v = t_comp'(int'($urandom_range(2 * ONE_Q_I)) - ONE_Q_I);
        endcase
        return v;
    endfunction

    // near-unit quaternion, so the product lands near magnitude one
    function automatic t_qpn_in rand_unit_pair();
        t_qpn_in q;
        int spread;
        spread = $urandom_range(1) ? 64 : 3000;
        q = make_pair(t_comp'($urandom_range(2 * spread) - spread),
                      t_comp'($urandom_range(2 * spread) - spread),
                      t_comp'($urandom_range(2 * spread) - spread),
                      t_comp'(ONE_Q_I - int'($urandom_range(spread))),
                      t_comp'($urandom_range(2 * spread) - spread),
                      t_comp'($urandom_range(2 * spread) - spread),
                      t_comp'($urandom_range(2 * spread) - spread),
                      $urandom_range(1) ? t_comp'(ONE_Q_I) : t_comp'(-ONE_Q_I));
        return q;
    endfunction

    task automatic test_directed();
        t_comp one, mx, mn;
        one = t_comp'(ONE_Q_I);
        mx  = t_comp'(COMP_MAX_I);
        mn  = t_comp'(COMP_MIN_I);
        send_pair(make_pair(0, 0, 0, one, 0, 0, 0, one));
        send_pair(make_pair(one, 0, 0, 0, 0, one, 0, 0));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(mx, mx, mx, mx, mx, mx, mx, mx));
        send_pair(make_pair(mn, mn, mn, mn, mn, mn, mn, mn));
        send_pair(make_pair(mn, mx, mn, mx, mx, mn, mx, mn));
        send_pair(make_pair(1, 0, 0, 0, 0, 0, 0, 1));
        send_pair(make_pair(0, 0, 0, 2, 0, 0, 0, t_comp'(8192)));
        send_pair(make_pair(0, 0, 0, t_comp'(8192), 0, 0, 0, t_comp'(8192)));
        send_pair(make_pair(0, 0, 0, t_comp'(-16383), 0, 0, 0, one));
        send_pair(make_pair(t_comp'(-1), t_comp'(-1), t_comp'(-1), t_comp'(-1),
                            t_comp'(-1), t_comp'(-1), t_comp'(-1), t_comp'(-1)));
        send_pair(make_pair(0, 0, 0, t_comp'(128), 0, 0, 0, t_comp'(64)));
        write_tolerance(15'd0);
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, one, 0, 0, 0, one));
        write_tolerance(15'd16384);
        send_pair(make_pair(0, 0, 0, one, 0, 0, 0, one));
        send_pair(make_pair(mx, mx, mx, mx, mx, mx, mx, mx));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        write_tolerance(15'h7FFF);
        send_pair(make_pair(mn, mn, mn, mn, mn, mn, mn, mn));
        send_pair(make_pair(0, 0, 0, t_comp'(200), 0, 0, 0, t_comp'(200)));
    endtask

    task automatic test_random(int count, logic [14:0] tol);
        write_tolerance(tol);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(1))
                send_pair(rand_unit_pair());
            else
                send_pair(make_pair(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                                    rand_comp(), rand_comp(), rand_comp(), rand_comp()));
        end
    endtask

    // sink holds off long enough for the pipeline to fill and stall
    task automatic test_backpressure();
        write_tolerance(15'd16);
        hold_sink = 1'b1;
        fork
            for (int n = 0; n < 120; n++) send_pair(rand_unit_pair());
            begin
                repeat (300) @(posedge i_clk);
                hold_sink = 1'b0;
            end
        join
    endtask

    task automatic test_no_idles();
        send_idles = 1'b0;
        sink_idles = 1'b0;
        test_random(200, 15'd32);
        send_idles = 1'b1;
        sink_idles = 1'b1;
    endtask

    // drive ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !hold_sink && !(sink_idles && $urandom_range(99) < 25);
        end
    end

    // check each output beat against the oldest expectation
    always @(posedge i_clk) begin
        t_qpn_out want;
        if (i_rst_n && watch.out_beat) begin
            if (expected_products.size() == 0) begin
                $display("%0t: unexpected beat, actual %p", $realtime, out_ch.payload);
                error_count++;
            end else begin
                want = expected_products.pop_front();
                beats_checked++;
                if (want.renormalized) renorm_seen++;
                else if (want.degenerate) degen_seen++;
                else unit_seen++;
                if (out_ch.payload.prod_x !== want.prod_x) begin
                    $display("%0t: prod_x expected %0d actual %0d", $realtime,
                             want.prod_x, out_ch.payload.prod_x);
                    error_count++;
                end
                if (out_ch.payload.prod_y !== want.prod_y) begin
                    $display("%0t: prod_y expected %0d actual %0d", $realtime,
                             want.prod_y, out_ch.payload.prod_y);
                    error_count++;
                end
                if (out_ch.payload.prod_z !== want.prod_z) begin
                    $display("%0t: prod_z expected %0d actual %0d", $realtime,
                             want.prod_z, out_ch.payload.prod_z);
                    error_count++;
                end
                if (out_ch.payload.prod_w !== want.prod_w) begin
                    $display("%0t: prod_w expected %0d actual %0d", $realtime,
                             want.prod_w, out_ch.payload.prod_w);
                    error_count++;
                end
                if (out_ch.payload.degenerate !== want.degenerate) begin
                    $display("%0t: degenerate expected %0b actual %0b", $realtime,
                             want.degenerate, out_ch.payload.degenerate);
                    error_count++;
                end
                if (out_ch.payload.renormalized !== want.renormalized) begin
                    $display("%0t: renormalized expected %0b actual %0b", $realtime,
                             want.renormalized, out_ch.payload.renormalized);
                    error_count++;
                end
            end
        end
    end

    // watchdog: count cycles without any beat
    always @(posedge i_clk) begin
        if (watch.in_beat || watch.out_beat) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400, 15'd1);
        test_backpressure();
        test_no_idles();
        test_random(300, 15'd200);
        test_random(250, 15'd0);
        test_random(200, 15'd16384);
        go_idle();
        $display("Sent %0d beats, checked %0d: %0d pass-through, %0d renormalized, %0d degenerate.",
                 beats_sent, beats_checked, unit_seen, renorm_seen, degen_seen);
        if (error_count == 0 && expected_products.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
